@@ design/otx_pkg.sv @@
// ----------------------------------------------------------------------------
// otx_pkg - shared definitions for the OOK repetition packet transmitter
// Widths, register indexes, phase codes, config and result structs, and the
// tick limit saturation function.
// ----------------------------------------------------------------------------
package otx_pkg;

   // width of the tick counter
   localparam int TICK_WIDTH = 24;

   // configuration field widths
   localparam int CFG_TICK_W  = 24;
   localparam int CFG_WORD_W  = 16;
   localparam int CFG_PAY_W   = 32;
   localparam int CFG_REP_W   = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // width wide enough to compare a config tick count against the cap
   localparam int TICK_CMP_W = (TICK_WIDTH > CFG_TICK_W) ? TICK_WIDTH : CFG_TICK_W;
   localparam logic [TICK_CMP_W-1:0] TICK_CAP = TICK_CMP_W'({TICK_WIDTH{1'b1}});

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PAYLOAD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CHIP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP      = 3'd5;

   // register reset values
   localparam logic [CFG_WORD_W-1:0] PREAMBLE_RESET = 16'hAAAA;
   localparam logic [CFG_WORD_W-1:0] SYNC_RESET     = 16'hD391;
   localparam logic [CFG_PAY_W-1:0]  PAYLOAD_RESET  = 32'h4F50_454E;
   localparam logic [CFG_TICK_W-1:0] CHIP_RESET     = 24'd50000;
   localparam logic [CFG_REP_W-1:0]  REPEAT_RESET   = 4'd3;
   localparam logic [CFG_TICK_W-1:0] GAP_RESET      = 24'd200000;

   typedef enum logic [1:0] {
      PHASE_PREAMBLE = 2'd0,
      PHASE_SYNC     = 2'd1,
      PHASE_PAYLOAD  = 2'd2,
      PHASE_GAP      = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CFG_WORD_W-1:0] preamble_word;
      logic [CFG_WORD_W-1:0] sync_word;
      logic [CFG_PAY_W-1:0]  payload_word;
      logic [CFG_TICK_W-1:0] chip_ticks;
      logic [CFG_REP_W-1:0]  repeat_chips;
      logic [CFG_TICK_W-1:0] gap_ticks;
   } cfg_type;

   typedef struct packed {
      logic      carrier_on;
      logic      frame_done;
      logic      frame_toggle;
      phase_type phase;
   } result_type;

   // saturate a configured tick count to what the counter can hold
   function automatic logic [TICK_WIDTH-1:0] tick_limit(input logic [CFG_TICK_W-1:0] value);
      logic [TICK_CMP_W-1:0] wide;
      wide = TICK_CMP_W'(value);
      if (wide > TICK_CAP) begin
         wide = TICK_CAP;
      end
      return TICK_WIDTH'(wide);
   endfunction

endpackage

@@ design/otx_if.sv @@
// ----------------------------------------------------------------------------
// otx_if - request and response channels of the transmitter
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface otx_req_if;
   logic valid;
   logic ready;
   logic enable;

   modport source (output valid, output enable, input ready);
   modport sink   (input valid, input enable, output ready);
endinterface

interface otx_rsp_if;
   logic              valid;
   logic              ready;
   logic              carrier_on;
   logic              frame_done;
   logic              frame_toggle;
   otx_pkg::phase_type phase;

   modport source (output valid, output carrier_on, output frame_done,
                   output frame_toggle, output phase, input ready);
   modport sink   (input valid, input carrier_on, input frame_done,
                   input frame_toggle, input phase, output ready);
endinterface

@@ design/otx_sequencer.sv @@
// ----------------------------------------------------------------------------
// otx_sequencer - frame position counters and per-tick result
// Holds byte, bit, chip and tick positions, the gap flag and the toggle bit;
// advances them a tick per accepted beat; enable low returns to frame start.
// ----------------------------------------------------------------------------
module otx_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 enable,
   input  otx_pkg::cfg_type     cfg,
   output otx_pkg::result_type  result
);

   logic [2:0]                     byte_ff, byte_in;
   logic [2:0]                     bit_ff, bit_in;
   logic [otx_pkg::CFG_REP_W-1:0]  chip_ff, chip_in;
   logic [otx_pkg::TICK_WIDTH-1:0] tick_ff, tick_in;
   logic                           gap_ff, gap_in;
   logic                           toggle_ff, toggle_in;

   logic [otx_pkg::TICK_WIDTH-1:0] gap_lim;
   logic [otx_pkg::TICK_WIDTH-1:0] chip_lim;
   logic [otx_pkg::CFG_REP_W-1:0]  rep_lim;
   logic [otx_pkg::TICK_WIDTH:0]   tick_sum;
   logic [otx_pkg::CFG_REP_W:0]    chip_sum;
   logic [63:0]                    frame;

   // limits with zero chip ticks and zero repeats read as one
   always_comb begin
      gap_lim  = otx_pkg::tick_limit(cfg.gap_ticks);
      chip_lim = otx_pkg::tick_limit(cfg.chip_ticks);
      if (chip_lim == '0) begin
         chip_lim = otx_pkg::TICK_WIDTH'(1);
      end
      rep_lim = cfg.repeat_chips;
      if (rep_lim == '0) begin
         rep_lim = otx_pkg::CFG_REP_W'(1);
      end
   end

   assign tick_sum = {1'b0, tick_ff} + (otx_pkg::TICK_WIDTH + 1)'(1);
   assign chip_sum = {1'b0, chip_ff} + (otx_pkg::CFG_REP_W + 1)'(1);
   assign frame    = {cfg.preamble_word, cfg.sync_word, cfg.payload_word};

   // next position and this tick's result
   always_comb begin
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      chip_in   = chip_ff;
      tick_in   = tick_ff;
      gap_in    = gap_ff;
      toggle_in = toggle_ff;
      result.carrier_on = 1'b0;
      result.frame_done = 1'b0;
      result.phase      = otx_pkg::PHASE_PREAMBLE;

      if (!enable) begin
         // drop back to the frame start, carrier off
         byte_in = '0;
         bit_in  = '0;
         chip_in = '0;
         tick_in = '0;
         gap_in  = 1'b0;
      end else if (gap_ff) begin
         result.phase = otx_pkg::PHASE_GAP;
         tick_in = tick_sum[otx_pkg::TICK_WIDTH-1:0];
         if (tick_sum >= {1'b0, gap_lim}) begin
            tick_in = '0;
            gap_in  = 1'b0;
         end
      end else begin
         // MSB first: bit index 63 - (byte * 8 + bit) is the complement
         result.carrier_on = frame[~{byte_ff, bit_ff}];
         if (byte_ff < 3'd2) begin
            result.phase = otx_pkg::PHASE_PREAMBLE;
         end else if (byte_ff < 3'd4) begin
            result.phase = otx_pkg::PHASE_SYNC;
         end else begin
            result.phase = otx_pkg::PHASE_PAYLOAD;
         end

         tick_in = tick_sum[otx_pkg::TICK_WIDTH-1:0];
         if (tick_sum >= {1'b0, chip_lim}) begin
            tick_in = '0;
            chip_in = chip_sum[otx_pkg::CFG_REP_W-1:0];
            if (chip_sum >= {1'b0, rep_lim}) begin
               chip_in = '0;
               bit_in  = bit_ff + 3'd1;
               if (bit_ff == 3'd7) begin
                  byte_in = byte_ff + 3'd1;
                  if (byte_ff == 3'd7) begin
                     result.frame_done = 1'b1;
                     toggle_in = ~toggle_ff;
                     gap_in    = (gap_lim != '0);
                  end
               end
            end
         end
      end
      result.frame_toggle = toggle_in;
   end

   // advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff   <= '0;
         bit_ff    <= '0;
         chip_ff   <= '0;
         tick_ff   <= '0;
         gap_ff    <= 1'b0;
         toggle_ff <= 1'b0;
      end else if (step) begin
         byte_ff   <= byte_in;
         bit_ff    <= bit_in;
         chip_ff   <= chip_in;
         tick_ff   <= tick_in;
         gap_ff    <= gap_in;
         toggle_ff <= toggle_in;
      end
   end

endmodule

@@ design/ook_repetition_packet_transmitter.sv @@
// ----------------------------------------------------------------------------
// ook_repetition_packet_transmitter - OOK repetition-coded frame source
// One request beat is one tick; each tick yields one response beat with the
// carrier enable, frame end pulse, frame toggle and frame phase.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   req_ch   in         valid / ready      enable
//   rsp_ch   out        valid / ready      carrier_on, frame_done,
//                                          frame_toggle, phase
//   csr_*    in         write enable only  index (3 bits), data (32 bits)
//
// For each beat, the position counters update in the cycle the request is
// accepted and the result lands in the response register.
// A new request is taken every cycle while the response register is empty
// or being drained, so a stalled sink holds off only the request side.
// Reset is synchronous: counters, toggle and response valid clear, and
// registers return to their default values.
// ----------------------------------------------------------------------------
module ook_repetition_packet_transmitter (
   input  logic                                clock,
   input  logic                                reset,
   otx_req_if.sink                             req_ch,
   otx_rsp_if.source                           rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [otx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [otx_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   otx_pkg::cfg_type    cfg_ff;
   otx_pkg::result_type next_result;
   otx_pkg::result_type result_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_word <= otx_pkg::PREAMBLE_RESET;
         cfg_ff.sync_word     <= otx_pkg::SYNC_RESET;
         cfg_ff.payload_word  <= otx_pkg::PAYLOAD_RESET;
         cfg_ff.chip_ticks    <= otx_pkg::CHIP_RESET;
         cfg_ff.repeat_chips  <= otx_pkg::REPEAT_RESET;
         cfg_ff.gap_ticks     <= otx_pkg::GAP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            otx_pkg::REG_PREAMBLE: begin
               cfg_ff.preamble_word <= csr_write_data[otx_pkg::CFG_WORD_W-1:0];
            end
            otx_pkg::REG_SYNC: begin
               cfg_ff.sync_word <= csr_write_data[otx_pkg::CFG_WORD_W-1:0];
            end
            otx_pkg::REG_PAYLOAD: begin
               cfg_ff.payload_word <= csr_write_data[otx_pkg::CFG_PAY_W-1:0];
            end
            otx_pkg::REG_CHIP: begin
               cfg_ff.chip_ticks <= csr_write_data[otx_pkg::CFG_TICK_W-1:0];
            end
            otx_pkg::REG_REPEAT: begin
               cfg_ff.repeat_chips <= csr_write_data[otx_pkg::CFG_REP_W-1:0];
            end
            otx_pkg::REG_GAP: begin
               cfg_ff.gap_ticks <= csr_write_data[otx_pkg::CFG_TICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // take a beat whenever the response register is free or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   otx_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .enable (req_ch.enable),
      .cfg    (cfg_ff),
      .result (next_result)
   );

   // hold the response until the sink takes it
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= next_result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.carrier_on   = result_ff.carrier_on;
   assign rsp_ch.frame_done   = result_ff.frame_done;
   assign rsp_ch.frame_toggle = result_ff.frame_toggle;
   assign rsp_ch.phase        = result_ff.phase;

   // an accepted beat always shows up as a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted beat produced no response");

   // an empty response register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("request stalled with empty response register");

   // frame end only comes out of the last payload chip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_done) |->
         (rsp_ch.phase == otx_pkg::PHASE_PAYLOAD))
      else $error("frame end outside payload phase");

   // a disabled tick gives carrier off at frame start
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.enable) |=>
         (!rsp_ch.carrier_on && !rsp_ch.frame_done &&
          rsp_ch.phase == otx_pkg::PHASE_PREAMBLE))
      else $error("disabled tick did not return to frame start");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - OOK repetition packet transmitter
// Feeds tick beats on the request channel and keeps a cycle-level model of the
// frame counters. Every response beat is checked field by field against the
// predicted carrier level, frame end pulse, frame toggle and phase. Registers
// are rewritten between runs of ticks, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [otx_pkg::CSR_INDEX_W-1:0] REG_SPARE = 3'd6;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_TICKS = 340;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [otx_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [otx_pkg::CSR_DATA_W-1:0] csr_write_data;

   otx_req_if req_if ();
   otx_rsp_if rsp_if ();

   ook_repetition_packet_transmitter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if.sink),
      .rsp_ch           (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow of the register file and the frame position counters
   otx_pkg::cfg_type cfg_shadow;
   int unsigned frame_byte;
   int unsigned frame_bit;
   int unsigned chip_count;
   int unsigned tick_count;
   logic        gap_active;
   logic        toggle_state;

   logic                enable_backlog[$];
   otx_pkg::result_type ticks_due[$];
   int          mismatch_count;
   bit          req_beat_taken;
   int          req_hold;
   int          rsp_hold;
   bit          req_steady;
   bit          rsp_steady;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // saturate a configured tick count to the counter width
   function automatic int unsigned tick_cap(
      input logic [otx_pkg::CFG_TICK_W-1:0] value);
      longint unsigned cap;
      cap = (64'd1 << otx_pkg::TICK_WIDTH) - 1;
      return (value > cap) ? int'(cap) : int'(value);
   endfunction

   // advance the frame position by one tick and return the expected beat
   function automatic otx_pkg::result_type advance_tick(input logic enable);
      otx_pkg::result_type beat;
      logic [63:0] frame;
      int unsigned chip_lim;
      int unsigned rep_lim;
      beat.carrier_on = 1'b0;
      beat.frame_done = 1'b0;
      beat.phase      = otx_pkg::PHASE_PREAMBLE;
      if (!enable) begin
         frame_byte = 0;
         frame_bit  = 0;
         chip_count = 0;
         tick_count = 0;
         gap_active = 1'b0;
      end else if (gap_active) begin
         beat.phase = otx_pkg::PHASE_GAP;
         tick_count++;
         if (tick_count >= tick_cap(cfg_shadow.gap_ticks)) begin
            tick_count = 0;
            gap_active = 1'b0;
         end
      end else begin
         frame = {cfg_shadow.preamble_word, cfg_shadow.sync_word, cfg_shadow.payload_word};
         chip_lim = tick_cap(cfg_shadow.chip_ticks);
         rep_lim  = cfg_shadow.repeat_chips;
         if (chip_lim == 0) chip_lim = 1;
         if (rep_lim == 0) rep_lim = 1;
         beat.carrier_on = frame[63 - (frame_byte * 8 + frame_bit)];
         if (frame_byte < 2) beat.phase = otx_pkg::PHASE_PREAMBLE;
         else if (frame_byte < 4) beat.phase = otx_pkg::PHASE_SYNC;
         else beat.phase = otx_pkg::PHASE_PAYLOAD;
         tick_count++;
         if (tick_count >= chip_lim) begin
            tick_count = 0;
            chip_count++;
            if (chip_count >= rep_lim) begin
               chip_count = 0;
               frame_bit++;
               if (frame_bit >= 8) begin
                  frame_bit = 0;
                  frame_byte++;
                  if (frame_byte >= 8) begin
                     frame_byte = 0;
                     beat.frame_done = 1'b1;
                     toggle_state = ~toggle_state;
                     gap_active = (tick_cap(cfg_shadow.gap_ticks) > 0);
                  end
               end
            end
         end
      end
      beat.frame_toggle = toggle_state;
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // short gaps mostly, a few long ones, none in steady stretches
   function automatic int pick_hold(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // word with an edge value now and then, junk above the register width
   function automatic logic [31:0] pick_word(input int width);
      logic [31:0] mask;
      logic [31:0] value;
      int          r;
      mask  = (width == 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 1;
      r     = $urandom_range(0, 9);
      value = (r == 0) ? 32'd0 : (r == 1) ? mask : ($urandom & mask);
      return value | ($urandom & ~mask);
   endfunction

   task automatic write_reg(input logic [otx_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         otx_pkg::REG_PREAMBLE:
            cfg_shadow.preamble_word = data[otx_pkg::CFG_WORD_W-1:0];
         otx_pkg::REG_SYNC:
            cfg_shadow.sync_word     = data[otx_pkg::CFG_WORD_W-1:0];
         otx_pkg::REG_PAYLOAD:
            cfg_shadow.payload_word  = data[otx_pkg::CFG_PAY_W-1:0];
         otx_pkg::REG_CHIP:
            cfg_shadow.chip_ticks    = data[otx_pkg::CFG_TICK_W-1:0];
         otx_pkg::REG_REPEAT:
            cfg_shadow.repeat_chips  = data[otx_pkg::CFG_REP_W-1:0];
         otx_pkg::REG_GAP:
            cfg_shadow.gap_ticks     = data[otx_pkg::CFG_TICK_W-1:0];
         default: ;
      endcase
   endtask

   // hold until every queued tick has gone through and been answered
   task automatic wait_idle();
      while (enable_backlog.size() != 0 || req_if.valid || ticks_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic queue_ticks(input int count, input int reset_odds);
      repeat (count) enable_backlog.push_back(($urandom_range(0, reset_odds) == 0) ? 1'b0 : 1'b1);
   endtask

   // request driver: present the next tick once the last beat is taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.enable  <= 1'b0;
         req_beat_taken = 1'b0;
         req_hold       = 0;
      end else if (!req_if.valid || req_beat_taken) begin
         if (req_beat_taken) begin
            req_beat_taken = 1'b0;
            req_hold       = pick_hold(req_steady);
         end
         if (req_hold > 0) begin
            req_hold--;
            req_if.valid <= 1'b0;
         end else if (enable_backlog.size() != 0) begin
            req_if.enable <= enable_backlog.pop_front();
            req_if.valid  <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response sink: open for one cycle, then stall for a random spell, which may be empty
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_hold     = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold     = pick_hold(rsp_steady);
      end
   end

   // monitor: check response beats, then predict for accepted ticks
   always @(posedge clock) begin
      otx_pkg::result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (ticks_due.size() == 0) begin
               report_mismatch("unexpected beat, phase", rsp_if.phase, 0);
            end else begin
               want = ticks_due.pop_front();
               if (rsp_if.carrier_on !== want.carrier_on)
                  report_mismatch("carrier_on", rsp_if.carrier_on, want.carrier_on);
               if (rsp_if.frame_done !== want.frame_done)
                  report_mismatch("frame_done", rsp_if.frame_done, want.frame_done);
               if (rsp_if.frame_toggle !== want.frame_toggle)
                  report_mismatch("frame_toggle", rsp_if.frame_toggle, want.frame_toggle);
               if (rsp_if.phase !== want.phase)
                  report_mismatch("phase", rsp_if.phase, want.phase);
            end
         end
         if (req_if.valid && req_if.ready) begin
            ticks_due.push_back(advance_tick(req_if.enable));
            req_beat_taken = 1'b1;
         end
      end
   end

   // watchdog: give up after a long spell with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int random_ticks;
      int run_ticks;
      int r;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = otx_pkg::REG_PREAMBLE;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.enable    = 1'b0;
      rsp_if.ready     = 1'b0;
      quiet_cycles     = 0;
      mismatch_count   = 0;
      req_steady       = 1'b0;
      rsp_steady       = 1'b0;
      cfg_shadow = '{otx_pkg::PREAMBLE_RESET, otx_pkg::SYNC_RESET,
                     otx_pkg::PAYLOAD_RESET, otx_pkg::CHIP_RESET,
                     otx_pkg::REPEAT_RESET, otx_pkg::GAP_RESET};
      frame_byte   = 0;
      frame_bit    = 0;
      chip_count   = 0;
      tick_count   = 0;
      gap_active   = 1'b0;
      toggle_state = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default registers: a few ticks, a drop of enable, then on again
      enable_backlog = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      wait_idle();

      // all-ones preamble, zero sync and payload, zero counts and no gap
      write_reg(otx_pkg::REG_PREAMBLE, 32'h0000_FFFF);
      write_reg(otx_pkg::REG_SYNC, 32'hFFFF_0000);
      write_reg(otx_pkg::REG_PAYLOAD, 32'h0000_0000);
      write_reg(otx_pkg::REG_CHIP, 32'h0000_0000);
      write_reg(otx_pkg::REG_REPEAT, 32'h0000_0000);
      write_reg(otx_pkg::REG_GAP, 32'h0000_0000);
      write_reg(REG_SPARE, 32'hFFFF_FFFF);
      queue_ticks(12, 1 << 30);
      wait_idle();

      // longest chip, most repeats, longest gap; then cut the chip short
      write_reg(otx_pkg::REG_CHIP, 32'h00FF_FFFF);
      write_reg(otx_pkg::REG_REPEAT, 32'h0000_000F);
      write_reg(otx_pkg::REG_GAP, 32'h00FF_FFFF);
      queue_ticks(3, 1 << 30);
      wait_idle();
      write_reg(otx_pkg::REG_CHIP, 32'h0000_0001);
      enable_backlog = '{1'b1, 1'b1, 1'b0};
      wait_idle();

      // random runs of ticks, registers rewritten between runs
      random_ticks = 0;
      for (int run = 0; random_ticks < RANDOM_TICKS; run++) begin
         if (run == 0 || $urandom_range(0, 1))
            write_reg(otx_pkg::REG_PREAMBLE, pick_word(otx_pkg::CFG_WORD_W));
         if (run == 0 || $urandom_range(0, 1))
            write_reg(otx_pkg::REG_SYNC, pick_word(otx_pkg::CFG_WORD_W));
         if (run == 0 || $urandom_range(0, 1))
            write_reg(otx_pkg::REG_PAYLOAD, pick_word(otx_pkg::CFG_PAY_W));
         if (run == 0 || $urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 19);
            write_reg(otx_pkg::REG_CHIP, {8'($urandom),
               (r == 0) ? 24'd0 : (r < 14) ? 24'd1 : (r < 17) ? 24'd2 :
               (r < 19) ? 24'($urandom_range(3, 6)) : 24'hFF_FFFF});
         end
         if (run == 0 || $urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 19);
            write_reg(otx_pkg::REG_REPEAT, {28'($urandom),
               (r == 0) ? 4'd0 : (r < 15) ? 4'd1 : (r < 18) ? 4'd2 :
               (r == 18) ? 4'd15 : 4'($urandom_range(3, 14))});
         end
         if (run == 0 || $urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 9);
            write_reg(otx_pkg::REG_GAP, {8'($urandom),
               (r < 4) ? 24'd0 : (r < 8) ? 24'($urandom_range(1, 6)) :
               (r == 8) ? 24'($urandom_range(20, 60)) : 24'hFF_FFFF});
         end
         if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE + 3'($urandom_range(0, 1)), $urandom);
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         run_ticks  = $urandom_range(50, 110);
         queue_ticks(run_ticks, 49);
         random_ticks += run_ticks;
         wait_idle();
      end

      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && ticks_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
